// File: sv/lsad_pkg.sv
// Shared types, codes and constants of the light sensor auto dimmer.
package lsad_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int DUTY_BITS_DEF   = 8;

  localparam int FRAC_BITS = 8;
  localparam int WEIGHT_W  = 9;
  localparam int LEVEL_CFG_W = 16;
  localparam int LIMIT_W   = 12;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int OP_W      = 2;
  localparam int FAULT_W   = 2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;

  localparam logic [WEIGHT_W-1:0]    FILTER_WEIGHT_RST = 9'd26;
  localparam logic [LEVEL_CFG_W-1:0] DEAD_BAND_RST     = 16'd1280;
  localparam logic [LEVEL_CFG_W-1:0] SLEW_STEP_RST     = 16'd512;
  localparam logic [LIMIT_W-1:0]     MIN_SPAN_RST      = 12'd200;
  localparam logic [LIMIT_W-1:0]     SHORT_LIMIT_RST   = 12'd10;
  localparam logic [LIMIT_W-1:0]     OPEN_LIMIT_RST    = 12'd4090;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_WEIGHT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLEW_STEP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPAN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_LIMIT    = 3'd5;

  typedef enum logic [OP_W-1:0] {
    OP_CAL      = 2'd0,
    OP_END_CAL  = 2'd1,
    OP_REGULATE = 2'd2,
    OP_HOLD     = 2'd3
  } op_t;

  typedef enum logic [FAULT_W-1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_SHORT = 2'd1,
    FAULT_OPEN  = 2'd2
  } fault_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SUM,
    ST_CLAMP,
    ST_NUMER,
    ST_DIV,
    ST_TARGET,
    ST_RAMP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic decode;
    logic sum;
    logic clamp;
    logic div_start;
    logic target;
    logic ramp;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic regulate_go;
    logic div_last;
  } status_t;

endpackage

// File: sv/lsad_div.sv
// Restoring serial divider, one quotient bit per cycle.
module lsad_div import lsad_pkg::*; #(
  parameter int DEN_W = SAMPLE_BITS_DEF,
  parameter int QUO_W = DUTY_BITS_DEF + FRAC_BITS,
  localparam int NUM_W = DEN_W + QUO_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo,
  output logic             last
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [DEN_W-1:0] rem_r, rem_nxt, den_r;
  logic [QUO_W-1:0] shq_r, shq_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [DEN_W:0]   trial, trial_diff;
  logic             ge;

  // The upper numerator part is below the divisor, so the quotient fits QUO_W bits.
  always_comb begin
    trial      = {rem_r, shq_r[QUO_W-1]};
    trial_diff = trial - {1'b0, den_r};
    ge         = trial >= {1'b0, den_r};
    rem_nxt    = ge ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
    shq_nxt    = {shq_r[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(QUO_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[NUM_W-1:QUO_W];
      shq_r <= num[QUO_W-1:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      shq_r <= shq_nxt;
    end
  end

  assign quo  = shq_r;
  assign last = busy_r && (cnt_r == CNT_W'(1));

endmodule

// File: sv/lsad_ctrl.sv
// Sequencing state machine and handshake control of the dimmer.
module lsad_ctrl import lsad_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = status.regulate_go ? ST_SUM : ST_EMIT;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = ST_NUMER;
      end
      ST_NUMER: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_last) begin
          state_nxt = ST_TARGET;
        end
      end
      ST_TARGET: begin
        cmd.target = 1'b1;
        state_nxt  = ST_RAMP;
      end
      ST_RAMP: begin
        cmd.ramp  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// File: sv/lsad_dpath.sv
// Datapath: configuration, calibration range, filter, mapping, target and ramp.
module lsad_dpath import lsad_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int DUTY_BITS   = DUTY_BITS_DEF,
  localparam int IN_DW  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_DW = ((DUTY_BITS + SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_UW = FAULT_W + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic [IN_DW-1:0]     in_tdata,
  input  logic [OP_W-1:0]      in_tuser,
  output logic [OUT_DW-1:0]    out_tdata,
  output logic [OUT_UW-1:0]    out_tuser
);

  localparam int SB    = SAMPLE_BITS;
  localparam int DB    = DUTY_BITS;
  localparam int SMW   = SB + FRAC_BITS;
  localparam int LVW   = DB + FRAC_BITS;
  localparam int NW    = SMW + DB;
  localparam int CMPW  = (SB > LIMIT_W) ? SB : LIMIT_W;
  localparam int RW    = ((LVW > LEVEL_CFG_W) ? LVW : LEVEL_CFG_W) + 1;
  localparam int PNW   = SB + WEIGHT_W;
  localparam int POW   = SMW + WEIGHT_W;
  localparam int SUMW  = SMW + WEIGHT_W + 1;

  // Configuration registers.
  logic [WEIGHT_W-1:0]    filter_weight_r;
  logic [LEVEL_CFG_W-1:0] dead_band_r, slew_step_r;
  logic [LIMIT_W-1:0]     min_span_r, short_limit_r, open_limit_r;

  // Block state.
  logic [SMW-1:0] smoothed_r;
  logic [LVW-1:0] target_r, ramped_r;
  logic [SB-1:0]  range_low_r, range_high_r;
  logic           range_ready_r;
  fault_t         fault_r;
  logic           dflt_r;

  // Per-transaction working registers.
  op_t             op_r;
  logic [SB-1:0]   sample_r;
  logic [PNW-1:0]  prod_new_r;
  logic [POW-1:0]  prod_old_r;
  logic [SMW-1:0]  clamp_r;
  logic            full_r;
  logic [OUT_DW-1:0] out_data_r, out_data_nxt;
  logic [OUT_UW-1:0] out_user_r, out_user_nxt;

  fault_t            fault_now;
  logic [SB-1:0]     span;
  logic              span_bad;
  logic [WEIGHT_W-1:0] w_new, w_old;
  logic [SUMW-1:0]   sum;
  logic [SMW-1:0]    smoothed_nxt;
  logic [SB-1:0]     lo_sel, hi_sel, den;
  logic [SMW-1:0]    lo_s, hi_s, clamp_lo, clamp_nxt, numer_x;
  logic [NW-1:0]     num;
  logic [LVW-1:0]    quo, cand, diff, ramped_nxt;
  logic [RW-1:0]     ramp_ext, tgt_ext, slew_ext, ramp_up, ramp_gap, ramp_down;
  logic              div_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_weight_r <= FILTER_WEIGHT_RST;
      dead_band_r     <= DEAD_BAND_RST;
      slew_step_r     <= SLEW_STEP_RST;
      min_span_r      <= MIN_SPAN_RST;
      short_limit_r   <= SHORT_LIMIT_RST;
      open_limit_r    <= OPEN_LIMIT_RST;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        REG_FILTER_WEIGHT: filter_weight_r <= cfg_wdata[WEIGHT_W-1:0];
        REG_DEAD_BAND:     dead_band_r     <= cfg_wdata[LEVEL_CFG_W-1:0];
        REG_SLEW_STEP:     slew_step_r     <= cfg_wdata[LEVEL_CFG_W-1:0];
        REG_MIN_SPAN:      min_span_r      <= cfg_wdata[LIMIT_W-1:0];
        REG_SHORT_LIMIT:   short_limit_r   <= cfg_wdata[LIMIT_W-1:0];
        REG_OPEN_LIMIT:    open_limit_r    <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // Fault limits; the short fault wins when both are hit.
    if (CMPW'(sample_r) <= CMPW'(short_limit_r)) begin
      fault_now = FAULT_SHORT;
    end else if (CMPW'(sample_r) >= CMPW'(open_limit_r)) begin
      fault_now = FAULT_OPEN;
    end else begin
      fault_now = FAULT_NONE;
    end

    span     = range_high_r - range_low_r;
    span_bad = (range_high_r < range_low_r) || (CMPW'(span) < CMPW'(min_span_r));

    w_new = (filter_weight_r > WEIGHT_ONE) ? WEIGHT_ONE : filter_weight_r;
    w_old = WEIGHT_ONE - w_new;

    sum          = SUMW'({prod_new_r, {FRAC_BITS{1'b0}}}) + SUMW'(prod_old_r);
    smoothed_nxt = sum[SMW+FRAC_BITS-1:FRAC_BITS];

    // Before the range is ready, regulation uses the full sample range.
    lo_sel    = range_ready_r ? range_low_r  : '0;
    hi_sel    = range_ready_r ? range_high_r : '1;
    lo_s      = {lo_sel, {FRAC_BITS{1'b0}}};
    hi_s      = {hi_sel, {FRAC_BITS{1'b0}}};
    clamp_lo  = (smoothed_r < lo_s) ? lo_s : smoothed_r;
    clamp_nxt = (clamp_lo > hi_s) ? hi_s : clamp_lo;

    // Inverse map numerator times full duty, as a shift and a subtract.
    numer_x = hi_s - clamp_r;
    num     = {numer_x, {DB{1'b0}}} - NW'(numer_x);
    den     = hi_sel - lo_sel;

    cand = full_r ? {{DB{1'b1}}, {FRAC_BITS{1'b0}}} : quo;
    diff = (cand > target_r) ? (cand - target_r) : (target_r - cand);

    ramp_ext  = RW'(ramped_r);
    tgt_ext   = RW'(target_r);
    slew_ext  = RW'(slew_step_r);
    ramp_up   = ramp_ext + slew_ext;
    ramp_gap  = ramp_ext - tgt_ext;
    ramp_down = ramp_ext - slew_ext;
    if (ramped_r < target_r) begin
      ramped_nxt = (ramp_up > tgt_ext) ? target_r : ramp_up[LVW-1:0];
    end else if (ramped_r > target_r) begin
      ramped_nxt = (ramp_gap > slew_ext) ? ramp_down[LVW-1:0] : target_r;
    end else begin
      ramped_nxt = ramped_r;
    end

    out_data_nxt = '0;
    out_data_nxt[DB-1:0] = (fault_r != FAULT_NONE) ? '0 : ramped_r[LVW-1:FRAC_BITS];
    out_data_nxt[DB+SB-1:DB] = smoothed_r[SMW-1:FRAC_BITS];
    out_user_nxt = {dflt_r, fault_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smoothed_r    <= '0;
      target_r      <= '0;
      ramped_r      <= '0;
      range_low_r   <= '1;
      range_high_r  <= '0;
      range_ready_r <= 1'b0;
      fault_r       <= FAULT_NONE;
      dflt_r        <= 1'b0;
    end else begin
      if (cmd.decode) begin
        fault_r <= (op_r == OP_REGULATE) ? fault_now : FAULT_NONE;
        dflt_r  <= (op_r == OP_END_CAL) && span_bad;
        unique case (op_r)
          OP_CAL: begin
            if (sample_r < range_low_r) begin
              range_low_r <= sample_r;
            end
            if (sample_r > range_high_r) begin
              range_high_r <= sample_r;
            end
          end
          OP_END_CAL: begin
            if (span_bad) begin
              range_low_r  <= '0;
              range_high_r <= '1;
            end
            range_ready_r <= 1'b1;
            smoothed_r    <= {sample_r, {FRAC_BITS{1'b0}}};
          end
          default: ;
        endcase
      end
      if (cmd.sum) begin
        smoothed_r <= smoothed_nxt;
      end
      if (cmd.target && (RW'(diff) > RW'(dead_band_r))) begin
        target_r <= cand;
      end
      if (cmd.ramp) begin
        ramped_r <= ramped_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r     <= op_t'(in_tuser);
      sample_r <= in_tdata[SB-1:0];
    end
    // Both filter products are formed here; they are used only on regulation.
    if (cmd.decode) begin
      prod_new_r <= PNW'(w_new) * PNW'(sample_r);
      prod_old_r <= POW'(w_old) * POW'(smoothed_r);
    end
    if (cmd.clamp) begin
      clamp_r <= clamp_nxt;
      full_r  <= (hi_sel <= lo_sel);
    end
    if (cmd.load_out) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  lsad_div #(
    .DEN_W (SB),
    .QUO_W (LVW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num),
    .den   (den),
    .quo   (quo),
    .last  (div_last)
  );

  assign status.regulate_go = (op_r == OP_REGULATE) && (fault_now == FAULT_NONE);
  assign status.div_last    = div_last;
  assign out_tdata          = out_data_r;
  assign out_tuser          = out_user_r;

endmodule

// File: sv/light_sensor_auto_dimmer_top.sv
// Top level of the light sensor auto dimmer: controller, datapath and ports.
//
//   Channel  Direction  Carries
//   in_      slave      tuser = op, tdata = sample
//   out_     master     tuser = fault_code, used_default_range;
//                       tdata = duty, filtered_level
//   cfg_     write      wen, addr = register index, wdata = value
//
// A regulate transaction steps from acceptance through decode, filter sum,
// clamp, numerator, the serial divider of the inverse range map (one quotient
// bit per cycle, the longest step), target, ramp and emit before the next
// acceptance. Calibration, hold and faulted ones skip from decode to emit.
// Reset is synchronous and active low; it loads the register defaults and
// empties the output register.
// A stalled result sits in the output register while the next input
// transaction is already taken and worked on; that one waits only at its end.
module light_sensor_auto_dimmer_top import lsad_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int DUTY_BITS   = DUTY_BITS_DEF,
  localparam int IN_DW  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_DW = ((DUTY_BITS + SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_UW = FAULT_W + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input transactions.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DW-1:0]     in_tdata,   // sample, zero padded
  input  logic [OP_W-1:0]      in_tuser,   // op
  // Result transactions.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_DW-1:0]    out_tdata,  // duty, filtered_level, zero padded
  output logic [OUT_UW-1:0]    out_tuser,  // fault_code, used_default_range
  // Register writes, for the user only while the block is idle; not enforced.
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cmd_t    cmd;
  status_t status;

  // The controller steps one transaction through the datapath at a time and
  // owns both handshakes; the datapath only reacts to its commands.
  lsad_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  // The datapath holds the registers, the filter, the range map with its
  // divider, the dead band gate, the slew ramp and the output register.
  lsad_dpath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .DUTY_BITS   (DUTY_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

// File: sv/lsad_checker.sv
// Port level checks of the dimmer, bound to the top level.
module lsad_checker import lsad_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int DUTY_BITS   = DUTY_BITS_DEF,
  localparam int IN_DW  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_DW = ((DUTY_BITS + SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_UW = FAULT_W + 1
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata,
  input logic [OUT_UW-1:0] out_tuser
);

  // One transaction is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken again right after a transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

  a_fault_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser[FAULT_W-1:0] != FAULT_NONE)) |-> (out_tdata[DUTY_BITS-1:0] == '0))
    else $error("faulted result with nonzero duty");

  a_default_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[FAULT_W]) |-> (out_tuser[FAULT_W-1:0] == FAULT_NONE))
    else $error("range fallback reported with a fault");

  a_fault_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[FAULT_W-1:0] != 2'd3))
    else $error("undefined fault code");

endmodule

bind light_sensor_auto_dimmer_top lsad_checker #(
  .SAMPLE_BITS (SAMPLE_BITS),
  .DUTY_BITS   (DUTY_BITS)
) u_lsad_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: sim/light_sensor_auto_dimmer_top_tb.sv
// Self-checking testbench of the light sensor auto dimmer: stream driver, monitor and predictor.
`timescale 1ns / 100ps

module light_sensor_auto_dimmer_top_tb;
  import lsad_pkg::*;

  // Cycles without any accepted transaction before the run is declared hung.
  // The longest legitimate quiet stretch is the forced receiver hold below.
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  // Settling time before a register write, a little above one regulate pass.
  localparam int SETTLE_CYCLES = 30;

  typedef struct packed {
    op_t         op;
    logic [11:0] sample;
  } sensor_item_t;

  typedef struct packed {
    logic [7:0]  duty;
    fault_t      fault;
    logic        dflt;
    logic [11:0] level;
  } dimmer_out_t;

  logic clk;
  logic rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;

  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;

  logic                 cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  light_sensor_auto_dimmer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // sample [11:0], zeros above
    .in_tuser   (in_tuser),   // op [1:0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // duty [7:0], filtered_level [19:8], zeros above
    .out_tuser  (out_tuser),  // fault_code [1:0], used_default_range [2]
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Samples waiting to be offered, and results the dimmer still owes us.
  sensor_item_t pending_samples[$];
  dimmer_out_t  expected_duty_q[$];
  int           queued_items = 0;

  // Shadow copy of the register file, written together with the DUT's.
  logic [8:0]  sh_weight    = FILTER_WEIGHT_RST;
  logic [15:0] sh_dead_band = DEAD_BAND_RST;
  logic [15:0] sh_slew      = SLEW_STEP_RST;
  logic [11:0] sh_min_span  = MIN_SPAN_RST;
  logic [11:0] sh_short     = SHORT_LIMIT_RST;
  logic [11:0] sh_open      = OPEN_LIMIT_RST;

  // Predicted internal state of the dimmer.
  logic [19:0] smooth_q   = '0;   // Q12.8 filtered light level
  logic [15:0] target_q   = '0;   // Q8.8 duty target
  logic [15:0] ramp_q     = '0;   // Q8.8 level now driven
  logic [11:0] cal_lo     = 12'd4095;
  logic [11:0] cal_hi     = '0;
  logic        cal_ready  = 1'b0;

  int   mismatches  = 0;
  int   idle_pct    = 22;
  int   holds_asked = 0;
  int   holds_done  = 0;
  int   hold_left   = 0;
  int   quiet_cycles = 0;
  logic in_fired    = 1'b0;

  // Computes the result of one accepted sample and advances the predicted state.
  function automatic dimmer_out_t dimmer_step(op_t op, logic [11:0] s);
    dimmer_out_t r;
    logic [8:0]  w;
    logic [63:0] acc;
    logic [63:0] num;
    logic [11:0] lo;
    logic [11:0] hi;
    logic [19:0] c;
    logic [31:0] cand;
    logic [31:0] diff;
    logic [31:0] n;
    r.fault = FAULT_NONE;
    r.dflt  = 1'b0;
    case (op)
      OP_CAL: begin
        if (s < cal_lo) cal_lo = s;
        if (s > cal_hi) cal_hi = s;
      end
      OP_END_CAL: begin
        // An inverted or too narrow range falls back to the full scale.
        if (cal_hi < cal_lo || (cal_hi - cal_lo) < sh_min_span) begin
          cal_lo = '0;
          cal_hi = 12'd4095;
          r.dflt = 1'b1;
        end
        cal_ready = 1'b1;
        smooth_q  = {s, 8'h00};
      end
      OP_REGULATE: begin
        if (s <= sh_short) begin
          r.fault = FAULT_SHORT;
        end else if (s >= sh_open) begin
          r.fault = FAULT_OPEN;
        end else begin
          w   = (sh_weight > 9'd256) ? 9'd256 : sh_weight;
          acc = 64'(w) * (64'(s) << 8) + (64'd256 - 64'(w)) * 64'(smooth_q);
          smooth_q = acc[27:8];
          lo = cal_ready ? cal_lo : 12'd0;
          hi = cal_ready ? cal_hi : 12'd4095;
          c  = smooth_q;
          if (c < {lo, 8'h00}) c = {lo, 8'h00};
          if (c > {hi, 8'h00}) c = {hi, 8'h00};
          // A collapsed range asks for full duty instead of dividing by zero.
          if (hi <= lo) begin
            cand = 32'hFF00;
          end else begin
            num  = 64'({hi, 8'h00} - c) * 64'd255;
            cand = 32'(num / 64'(hi - lo)) & 32'hFFFF;
          end
          diff = (cand > 32'(target_q)) ? cand - 32'(target_q) : 32'(target_q) - cand;
          if (diff > 32'(sh_dead_band)) target_q = cand[15:0];
          if (ramp_q < target_q) begin
            n = 32'(ramp_q) + 32'(sh_slew);
            ramp_q = (n > 32'(target_q)) ? target_q : n[15:0];
          end else if (ramp_q > target_q) begin
            ramp_q = (ramp_q - target_q > sh_slew) ? ramp_q - sh_slew : target_q;
          end
        end
      end
      default: ;
    endcase
    r.duty  = (r.fault == FAULT_NONE) ? ramp_q[15:8] : 8'h00;
    r.level = smooth_q[19:8];
    return r;
  endfunction

  function automatic logic [11:0] clip(int v);
    if (v < 0) return 12'd0;
    if (v > 4095) return 12'd4095;
    return v[11:0];
  endfunction

  function automatic logic [11:0] near(int center, int spread);
    return clip(center + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  task automatic add_item(op_t op, logic [11:0] s);
    sensor_item_t it;
    it.op     = op;
    it.sample = s;
    pending_samples.push_back(it);
    queued_items++;
  endtask

  // Waits until every sample went in and every result came out, then lets the
  // datapath settle so that a register write finds the block idle.
  task automatic drain();
    while (pending_samples.size() != 0 || in_tvalid || expected_duty_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_FILTER_WEIGHT: sh_weight    = val[8:0];
      REG_DEAD_BAND:     sh_dead_band = val;
      REG_SLEW_STEP:     sh_slew      = val;
      REG_MIN_SPAN:      sh_min_span  = val[11:0];
      REG_SHORT_LIMIT:   sh_short     = val[11:0];
      REG_OPEN_LIMIT:    sh_open      = val[11:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic program_regs(int w, int db, int sl, int ms, int sh, int op);
    write_reg(REG_FILTER_WEIGHT, 16'(w));
    write_reg(REG_DEAD_BAND, 16'(db));
    write_reg(REG_SLEW_STEP, 16'(sl));
    write_reg(REG_MIN_SPAN, 16'(ms));
    write_reg(REG_SHORT_LIMIT, 16'(sh));
    write_reg(REG_OPEN_LIMIT, 16'(op));
    cfg_wen <= 1'b0;
  endtask

  // Random dimming sessions: a calibration sweep around some light level, mostly
  // an end of calibration, then a run of regulate samples near that level. Fault
  // limits, full-scale samples and stray ops are sprinkled in as noise.
  task automatic queue_sessions(int budget);
    int start;
    int center;
    int spread;
    int k;
    int nreg;
    int pick;
    start = queued_items;
    while (queued_items - start < budget) begin
      center = $urandom_range(0, 4095);
      spread = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 2000);
      for (k = $urandom_range(0, 6); k > 0; k--)
        add_item(OP_CAL, near(center, spread));
      if ($urandom_range(0, 9) != 0)
        add_item(OP_END_CAL, near(center, spread));
      nreg = $urandom_range(3, 25);
      for (k = 0; k < nreg; k++) begin
        pick = $urandom_range(0, 19);
        case (pick)
          0: add_item(OP_REGULATE, clip(int'(sh_short) + int'($urandom_range(0, 2)) - 1));
          1: add_item(OP_REGULATE, clip(int'(sh_open) + int'($urandom_range(0, 2)) - 1));
          2: add_item(OP_REGULATE, 12'($urandom_range(0, 4095)));
          3: add_item(op_t'($urandom_range(0, 3)), 12'($urandom_range(0, 4095)));
          default: add_item(OP_REGULATE, near(center, spread));
        endcase
      end
    end
  endtask

  // Driver: offers the next pending sample at the falling edge, keeping
  // tvalid and the payload steady until the transaction is taken.
  always @(negedge clk) begin
    sensor_item_t nxt;
    if (rst_n && (!in_tvalid || in_fired)) begin
      if (pending_samples.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        nxt = pending_samples.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {4'h0, nxt.sample};
        in_tuser  <= nxt.op;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus an occasional long hold counted
  // here so the dimmer fills up and has to stall its input.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (holds_asked != holds_done) begin
      holds_done <= holds_done + 1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // Monitor: checks each result transaction against the oldest prediction,
  // then predicts the result of any input transaction taken at this edge.
  always @(posedge clk) begin
    dimmer_out_t want;
    dimmer_out_t got;
    in_fired <= in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.duty  = out_tdata[7:0];
        got.level = out_tdata[19:8];
        got.fault = fault_t'(out_tuser[1:0]);
        got.dflt  = out_tuser[2];
        if (expected_duty_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result: duty %0d fault %0d default %0d level %0d",
                     got.duty, got.fault, got.dflt, got.level);
        end else begin
          want = expected_duty_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"Mismatch: duty %0d/%0d fault %0d/%0d default %0d/%0d ",
                        "level %0d/%0d (expected/actual)"},
                       want.duty, got.duty, want.fault, got.fault,
                       want.dflt, got.dflt, want.level, got.level);
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_duty_q.push_back(dimmer_step(op_t'(in_tuser), in_tdata[11:0]));
    end
  end

  // Watchdog: a long run of cycles without any transaction means a hang.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int p;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // The range is fresh only once, so the zero-span case comes first: with
    // min_span at zero a single calibration level is accepted as the range.
    write_reg(REG_MIN_SPAN, 16'd0);
    cfg_wen <= 1'b0;
    @(negedge clk);
    add_item(OP_HOLD, 12'd4095);
    add_item(OP_REGULATE, 12'd2048);   // range not ready yet: full scale used
    add_item(OP_REGULATE, 12'd11);
    add_item(OP_REGULATE, 12'd4089);
    add_item(OP_REGULATE, 12'd10);     // short limit reached exactly
    add_item(OP_REGULATE, 12'd0);
    add_item(OP_REGULATE, 12'd4090);   // open limit reached exactly
    add_item(OP_REGULATE, 12'd4095);
    add_item(OP_CAL, 12'd2000);
    add_item(OP_CAL, 12'd2000);
    add_item(OP_END_CAL, 12'd2000);
    add_item(OP_REGULATE, 12'd2000);   // collapsed range: full duty target
    add_item(OP_REGULATE, 12'd2500);
    add_item(OP_REGULATE, 12'd1500);
    drain();

    // Back to the default span: a narrow sweep falls back to the full range,
    // which calibration samples at the scale ends after the end cannot widen.
    write_reg(REG_MIN_SPAN, 16'(MIN_SPAN_RST));
    cfg_wen <= 1'b0;
    @(negedge clk);
    add_item(OP_CAL, 12'd2100);
    add_item(OP_END_CAL, 12'd2100);
    add_item(OP_CAL, 12'd0);
    add_item(OP_CAL, 12'd4095);
    add_item(OP_REGULATE, 12'd3000);
    add_item(OP_REGULATE, 12'd1000);
    add_item(OP_END_CAL, 12'd3000);
    add_item(OP_REGULATE, 12'd3000);
    add_item(OP_REGULATE, 12'd500);
    add_item(OP_HOLD, 12'd0);
    drain();

    // Extremes: raw samples, no dead band, unlimited slew, widest span.
    program_regs(256, 0, 65535, 4095, 0, 4095);
    queue_sessions(150);
    drain();

    // Opposite extremes: frozen filter and ramp, both fault limits at zero,
    // so a zero sample hits both and the short fault must win.
    program_regs(0, 65535, 0, 1, 0, 0);
    queue_sessions(40);
    drain();

    // Every regulate sample counts as a short here.
    program_regs(511, 0, 1, 4095, 4095, 4095);
    queue_sessions(30);
    drain();

    for (p = 0; p < 10; p++) begin
      program_regs(($urandom_range(0, 4) == 0) ? $urandom_range(257, 511)
                                               : $urandom_range(0, 256),
                   ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, 3000),
                   ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(1, 2000),
                   ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
                                               : $urandom_range(1, 600),
                   ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
                                               : $urandom_range(0, 200),
                   ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
                                               : $urandom_range(3800, 4095));
      // One phase runs without any idling, another starts with a long hold.
      idle_pct = (p == 3) ? 0 : 22;
      if (p == 5) holds_asked++;
      queue_sessions(120);
      drain();
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: light_sensor_auto_dimmer_top.f
sv/lsad_pkg.sv
sv/lsad_div.sv
sv/lsad_ctrl.sv
sv/lsad_dpath.sv
sv/light_sensor_auto_dimmer_top.sv
sv/lsad_checker.sv
sim/light_sensor_auto_dimmer_top_tb.sv
